@@ src/csseq_pkg.sv @@
// ----------------------------------------------------------------------------
// csseq_pkg
// Shared types and codes for the converter supervisor sequencer.
// ----------------------------------------------------------------------------
package csseq_pkg;

  // action codes carried by each input beat
  localparam logic [1:0] ACT_TICK  = 2'd0;
  localparam logic [1:0] ACT_START = 2'd1;
  localparam logic [1:0] ACT_STOP  = 2'd2;
  localparam logic [1:0] ACT_CLEAR = 2'd3;

  // sticky fault flag positions
  localparam int unsigned FLT_DCBUS      = 0;
  localparam int unsigned FLT_OVERCURRENT = 1;
  localparam int unsigned FLT_ESTOP      = 2;
  localparam int unsigned FLT_PROTECTION = 3;
  localparam int unsigned FLT_HAL        = 4;

  // hazard input bit positions
  localparam int unsigned HZ_ESTOP = 0;
  localparam int unsigned HZ_PROT  = 1;
  localparam int unsigned HZ_ADC   = 2;
  localparam int unsigned HZ_DUTY  = 3;

  // controller status bit positions
  localparam int unsigned ST_UNDERVOLT = 0;
  localparam int unsigned ST_PLL_LOST  = 1;
  localparam int unsigned ST_PLL_LOCK  = 2;

  localparam int unsigned NUM_PHASES = 6;

  typedef logic signed [15:0] meas_t;
  typedef meas_t phase_arr_t [NUM_PHASES];

  // frame check verdict
  typedef struct packed {
    logic bus_bad;
    logic over_cur;
  } frame_stat_t;

endpackage

@@ src/csseq_frame_chk.sv @@
// ----------------------------------------------------------------------------
// csseq_frame_chk
// Bus voltage window and phase current magnitude checks for one frame.
// ----------------------------------------------------------------------------
module csseq_frame_chk
  import csseq_pkg::*;
(
  input  meas_t       bus_voltage,
  input  meas_t       bus_min,
  input  meas_t       bus_max,
  input  logic [14:0] current_limit,
  input  phase_arr_t  currents,
  output frame_stat_t stat
);

  logic [NUM_PHASES-1:0] over;

  // magnitude as 16-bit unsigned so the most negative value maps to 32768
  always_comb begin
    for (int k = 0; k < NUM_PHASES; k++) begin
      logic [15:0] mag;
      mag = currents[k][15] ? (~currents[k] + 16'd1) : currents[k];
      over[k] = mag > {1'b0, current_limit};
    end
  end

  // window check, signed compare
  assign stat.bus_bad  = (bus_voltage < bus_min) || (bus_voltage > bus_max);
  assign stat.over_cur = |over;

endmodule

@@ src/converter_supervisor_sequencer_top.sv @@
// pipeline: input register, then result register; out_ready low with a full result stalls
// throughput: one beat per clock when not stalled; mode update is one pass between registers
// reset: synchronous active-low rst_n; mode returns to init, fault flags, timers and
// enables clear, configuration registers take their default values
// ----------------------------------------------------------------------------
// converter_supervisor_sequencer_top
// Sequences a two-converter power stage through init, precharge, sync and
// run, latches sticky fault flags and issues step, reset and half-duty strobes.
// ----------------------------------------------------------------------------
module converter_supervisor_sequencer_top
  import csseq_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  // configuration port
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [31:0]        cfg_wdata,
  // input channel
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [1:0]         in_action,
  input  logic [31:0]        in_time_us,
  input  logic [3:0]         in_hazard_bits,
  input  logic [2:0]         in_ctrl_status,
  input  logic signed [15:0] in_bus_voltage,
  input  logic signed [15:0] in_src_current_a,
  input  logic signed [15:0] in_src_current_b,
  input  logic signed [15:0] in_src_current_c,
  input  logic signed [15:0] in_rect_current_a,
  input  logic signed [15:0] in_rect_current_b,
  input  logic signed [15:0] in_rect_current_c,
  // result channel
  output logic               out_valid,
  input  logic               out_ready,
  output logic [2:0]         out_mode,
  output logic [4:0]         out_fault_bits,
  output logic               out_pwm_off,
  output logic               out_src_enable,
  output logic               out_rect_enable,
  output logic               out_ctrl_reset,
  output logic               out_src_step,
  output logic               out_rect_step,
  output logic               out_rect_half_duty
);

  typedef enum logic [2:0] {
    MODE_INIT      = 3'd0,
    MODE_PRECHARGE = 3'd1,
    MODE_SYNC      = 3'd2,
    MODE_RUN       = 3'd3,
    MODE_FAULT     = 3'd4
  } mode_t;

  typedef enum logic [2:0] {
    REG_BUS_MIN   = 3'd0,
    REG_BUS_MAX   = 3'd1,
    REG_CUR_LIMIT = 3'd2,
    REG_PRE_DELAY = 3'd3,
    REG_SYNC_TGT  = 3'd4
  } reg_idx_t;

  // configuration registers
  meas_t       bus_min_r;
  meas_t       bus_max_r;
  logic [14:0] cur_limit_r;
  logic [31:0] pre_delay_r;
  logic [15:0] sync_tgt_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bus_min_r   <= 16'sd0;
      bus_max_r   <= 16'sd32767;
      cur_limit_r <= 15'd32767;
      pre_delay_r <= 32'd500000;
      sync_tgt_r  <= 16'd1000;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_BUS_MIN:   bus_min_r   <= cfg_wdata[15:0];
        REG_BUS_MAX:   bus_max_r   <= cfg_wdata[15:0];
        REG_CUR_LIMIT: cur_limit_r <= cfg_wdata[14:0];
        REG_PRE_DELAY: pre_delay_r <= cfg_wdata;
        REG_SYNC_TGT:  sync_tgt_r  <= cfg_wdata[15:0];
        default: ;
      endcase
    end
  end

  // input register stage
  logic        s1_v_r;
  logic [1:0]  s1_action_r;
  logic [31:0] s1_time_r;
  logic [3:0]  s1_hz_r;
  logic [2:0]  s1_st_r;
  meas_t       s1_bus_r;
  phase_arr_t  s1_cur_r;
  logic        adv;

  assign adv      = s1_v_r && (!out_valid || out_ready);
  assign in_ready = !s1_v_r || adv;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
    end else if (in_ready) begin
      s1_v_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      s1_action_r <= in_action;
      s1_time_r   <= in_time_us;
      s1_hz_r     <= in_hazard_bits;
      s1_st_r     <= in_ctrl_status;
      s1_bus_r    <= in_bus_voltage;
      s1_cur_r[0] <= in_src_current_a;
      s1_cur_r[1] <= in_src_current_b;
      s1_cur_r[2] <= in_src_current_c;
      s1_cur_r[3] <= in_rect_current_a;
      s1_cur_r[4] <= in_rect_current_b;
      s1_cur_r[5] <= in_rect_current_c;
    end
  end

  // frame checks
  frame_stat_t fstat;

  csseq_frame_chk u_frame_chk (
    .bus_voltage   (s1_bus_r),
    .bus_min       (bus_min_r),
    .bus_max       (bus_max_r),
    .current_limit (cur_limit_r),
    .currents      (s1_cur_r),
    .stat          (fstat)
  );

  // sequencer state
  mode_t       mode_r, mode_nxt;
  logic [4:0]  fault_r, fault_nxt;
  logic [31:0] entered_r, entered_nxt;
  logic [15:0] sync_cnt_r, sync_cnt_nxt;
  logic        src_en_r, src_en_nxt;
  logic        rect_en_r, rect_en_nxt;
  logic        pwm_off_nxt, creset_nxt, sstep_nxt, rstep_nxt, half_nxt;
  logic        frame_ok;
  logic        pre_done;
  logic [31:0] elapsed;
  logic [15:0] sync_inc;

  assign frame_ok = !fstat.bus_bad && !fstat.over_cur;
  assign elapsed  = s1_time_r - entered_r;
  assign pre_done = elapsed >= pre_delay_r;
  assign sync_inc = (sync_cnt_r != 16'hFFFF) ? sync_cnt_r + 16'd1 : sync_cnt_r;

  // next-state logic for one beat
  always_comb begin
    mode_nxt     = mode_r;
    fault_nxt    = fault_r;
    entered_nxt  = entered_r;
    sync_cnt_nxt = sync_cnt_r;
    src_en_nxt   = src_en_r;
    rect_en_nxt  = rect_en_r;
    pwm_off_nxt  = 1'b0;
    creset_nxt   = 1'b0;
    sstep_nxt    = 1'b0;
    rstep_nxt    = 1'b0;
    half_nxt     = 1'b0;
    case (s1_action_r)
      ACT_START: begin
        if (mode_r == MODE_INIT) begin
          mode_nxt    = MODE_PRECHARGE;
          entered_nxt = s1_time_r;
        end
      end
      ACT_STOP: begin
        pwm_off_nxt = 1'b1;
        src_en_nxt  = 1'b0;
        rect_en_nxt = 1'b0;
        mode_nxt    = MODE_INIT;
      end
      ACT_CLEAR: begin
        if (mode_r == MODE_FAULT) begin
          fault_nxt  = '0;
          creset_nxt = 1'b1;
          mode_nxt   = MODE_INIT;
        end
      end
      default: begin
        if (s1_hz_r[HZ_ESTOP]) begin
          fault_nxt[FLT_ESTOP] = 1'b1;
          mode_nxt             = MODE_FAULT;
          pwm_off_nxt          = 1'b1;
        end else if (s1_hz_r[HZ_PROT]) begin
          fault_nxt[FLT_PROTECTION] = 1'b1;
          mode_nxt                  = MODE_FAULT;
          pwm_off_nxt               = 1'b1;
        end else if (s1_hz_r[HZ_ADC]) begin
          fault_nxt[FLT_HAL] = 1'b1;
          mode_nxt           = MODE_FAULT;
          pwm_off_nxt        = 1'b1;
        end else if ((mode_r == MODE_PRECHARGE || mode_r == MODE_SYNC ||
                      mode_r == MODE_RUN) && !frame_ok) begin
          // bus window takes priority over overcurrent
          if (fstat.bus_bad) begin
            fault_nxt[FLT_DCBUS] = 1'b1;
          end else begin
            fault_nxt[FLT_OVERCURRENT] = 1'b1;
          end
          mode_nxt    = MODE_FAULT;
          pwm_off_nxt = 1'b1;
        end else begin
          case (mode_r)
            MODE_PRECHARGE: begin
              if (pre_done) begin
                mode_nxt     = MODE_SYNC;
                sync_cnt_nxt = '0;
                creset_nxt   = 1'b1;
              end
            end
            MODE_SYNC: begin
              sstep_nxt = 1'b1;
              half_nxt  = 1'b1;
              if (s1_hz_r[HZ_DUTY]) begin
                fault_nxt[FLT_HAL] = 1'b1;
                mode_nxt           = MODE_FAULT;
                pwm_off_nxt        = 1'b1;
              end else begin
                src_en_nxt   = !s1_st_r[ST_UNDERVOLT];
                rect_en_nxt  = 1'b0;
                sync_cnt_nxt = sync_inc;
                if (sync_inc >= sync_tgt_r) begin
                  mode_nxt = MODE_RUN;
                end
              end
            end
            MODE_RUN: begin
              sstep_nxt = 1'b1;
              rstep_nxt = 1'b1;
              if (s1_hz_r[HZ_DUTY]) begin
                if (s1_st_r[ST_PLL_LOST]) begin
                  rect_en_nxt = 1'b0;
                end
                fault_nxt[FLT_HAL] = 1'b1;
                mode_nxt           = MODE_FAULT;
                pwm_off_nxt        = 1'b1;
              end else begin
                src_en_nxt  = !s1_st_r[ST_UNDERVOLT];
                rect_en_nxt = s1_st_r[ST_PLL_LOCK];
              end
            end
            default: begin
              // init and fault hold outputs off
              pwm_off_nxt = 1'b1;
            end
          endcase
        end
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r     <= MODE_INIT;
      fault_r    <= '0;
      entered_r  <= '0;
      sync_cnt_r <= '0;
      src_en_r   <= 1'b0;
      rect_en_r  <= 1'b0;
    end else if (adv) begin
      mode_r     <= mode_nxt;
      fault_r    <= fault_nxt;
      entered_r  <= entered_nxt;
      sync_cnt_r <= sync_cnt_nxt;
      src_en_r   <= src_en_nxt;
      rect_en_r  <= rect_en_nxt;
    end
  end

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_mode           <= mode_nxt;
      out_fault_bits     <= fault_nxt;
      out_pwm_off        <= pwm_off_nxt;
      out_src_enable     <= src_en_nxt;
      out_rect_enable    <= rect_en_nxt;
      out_ctrl_reset     <= creset_nxt;
      out_src_step       <= sstep_nxt;
      out_rect_step      <= rstep_nxt;
      out_rect_half_duty <= half_nxt;
    end
  end

`ifndef ASSERT_OFF
  // outputs are only forced off in init or fault
  a_pwm_off_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_pwm_off |-> out_mode == MODE_INIT || out_mode == MODE_FAULT)
    else $error("pwm_off outside init or fault");

  // rectifier never steps without the source controller, and never with half duty
  a_rstep_sstep: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_rect_step |-> out_src_step && !out_rect_half_duty)
    else $error("rectifier step without source step or with half duty");

  // controller reset only on entering sync or clearing a fault
  a_creset_mode: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_ctrl_reset |-> out_mode == MODE_SYNC || out_mode == MODE_INIT)
    else $error("ctrl_reset with unexpected mode");

  // state only moves when a beat passes to the result register
  a_state_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !adv |=> $stable(mode_r) && $stable(fault_r))
    else $error("sequencer state changed without a beat");
`endif

endmodule
